FILE: hdl/snh_pkg.sv
package snh_pkg;

  localparam int unsigned ActW      = 2;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned NumCoords = 4;
  localparam int unsigned SlotW     = 12;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned ExtW      = 13;
  localparam int unsigned InDataW   = ((NumCoords * CoordW + SlotW + 7) / 8) * 8;
  localparam int unsigned OutBits   = TotalW + SlotW + 2;
  localparam int unsigned OutDataW  = ((OutBits + 7) / 8) * 8;
  localparam logic [ExtW-1:0] ExtentReset = 13'd4096;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    REG_SLICE_MODE   = 1'b0,
    REG_SLICE_EXTENT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic mem_rd;
    logic mem_inc;
    logic sweep;
    logic sweep_all;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e in_act;
    logic    in_hit;
    action_e act_q;
    logic    ext_zero;
    logic    sweep_last;
    logic    out_free;
  } ctrl_sts_t;

endpackage

FILE: hdl/snh_dp.sv
module snh_dp
  import snh_pkg::*;
#(
  parameter int unsigned NUM_MODES   = 4,
  parameter int unsigned SLICE_SLOTS = 4096,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  reg_idx_e                        cfg_index_i,
  input  logic [ExtW-1:0]                 cfg_data_i,
  input  action_e                         in_action_i,
  input  logic [NumCoords-1:0][CoordW-1:0] in_coord_i,
  input  logic [SlotW-1:0]                in_read_slot_i,
  input  ctrl_cmd_t                       cmd_i,
  output ctrl_sts_t                       sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [TotalW-1:0]               out_total_o,
  output logic [SlotW-1:0]                out_used_o,
  output logic                            out_oor_o,
  output logic                            out_sat_o
);

  localparam int unsigned AW   = (SLICE_SLOTS > 1) ? $clog2(SLICE_SLOTS) : 1;
  localparam int unsigned LimW = (AW + 1 > ExtW) ? AW + 1 : ExtW;
  localparam int unsigned SlotsCap = (SLICE_SLOTS < 8191) ? SLICE_SLOTS : 8191;
  localparam logic [ExtW-1:0] SlotsCapW  = ExtW'(SlotsCap);
  localparam logic [3:0]      NumModesW  = 4'(NUM_MODES);
  localparam logic [LimW-1:0] AllSlotsW  = LimW'(SLICE_SLOTS);

  logic [ModeW-1:0]      mode_q;
  logic [ExtW-1:0]       extent_q;
  logic [ExtW-1:0]       eff_ext;
  logic                  mode_ok;
  logic [CoordW-1:0]     sel_coord;
  logic                  in_hit;

  action_e               act_q;
  logic                  hit_q;
  logic [CoordW-1:0]     slot_q;
  logic [AW-1:0]         addr;

  logic [AW-1:0]         idx_q, idx_d;
  logic [LimW-1:0]       sweep_lim;
  logic                  sweep_last;

  logic [COUNT_BITS-1:0] mem_q [SLICE_SLOTS];
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  sat;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [COUNT_BITS-1:0] wdata;

  logic                  out_valid_q, out_valid_d;
  logic [TotalW-1:0]     total_q, res_total;
  logic [SlotW-1:0]      used_q, res_used;
  logic                  oor_q, res_oor;
  logic                  sat_q, res_sat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      extent_q <= ExtentReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SLICE_MODE:   mode_q   <= cfg_data_i[ModeW-1:0];
        REG_SLICE_EXTENT: extent_q <= cfg_data_i;
        default:          mode_q   <= mode_q;
      endcase
    end
  end

  assign eff_ext   = (extent_q > SlotsCapW) ? SlotsCapW : extent_q;
  assign mode_ok   = {2'b00, mode_q} < NumModesW;
  assign sel_coord = in_coord_i[mode_q];

  always_comb begin
    case (in_action_i)
      ACT_COUNT: in_hit = mode_ok && (sel_coord < CoordW'(eff_ext));
      ACT_READ:  in_hit = ExtW'(in_read_slot_i) < eff_ext;
      default:   in_hit = 1'b0;
    endcase
  end

  // item capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_NOP;
      hit_q <= 1'b0;
    end else if (cmd_i.latch) begin
      act_q <= in_action_i;
      hit_q <= in_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      slot_q <= (in_action_i == ACT_COUNT) ? sel_coord : CoordW'(in_read_slot_i);
    end
  end

  assign addr = AW'(slot_q);

  // clearing sweep, wraps to zero after its last slot
  assign sweep_lim  = cmd_i.sweep_all ? AllSlotsW : LimW'(eff_ext);
  assign sweep_last = (LimW'(idx_q) + LimW'(1)) == sweep_lim;
  assign idx_d      = sweep_last ? '0 : idx_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.sweep) begin
      idx_q <= idx_d;
    end
  end

  // counter store, one write port and one registered read port
  assign sat      = rdata_q == {COUNT_BITS{1'b1}};
  assign cnt_next = sat ? rdata_q : rdata_q + COUNT_BITS'(1);
  assign we       = cmd_i.sweep | cmd_i.mem_inc;
  assign waddr    = cmd_i.sweep ? idx_q : addr;
  assign wdata    = cmd_i.sweep ? '0 : cnt_next;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  // result word; rdata_q still holds the pre-increment count here
  always_comb begin
    res_total = '0;
    res_used  = '0;
    res_oor   = 1'b0;
    res_sat   = 1'b0;
    case (act_q)
      ACT_COUNT: begin
        if (hit_q) begin
          res_total = TotalW'(cnt_next);
          res_used  = slot_q[SlotW-1:0];
          res_sat   = sat;
        end else begin
          res_oor   = 1'b1;
        end
      end
      ACT_READ: begin
        res_used = slot_q[SlotW-1:0];
        if (hit_q) begin
          res_total = TotalW'(rdata_q);
        end else begin
          res_oor   = 1'b1;
        end
      end
      default: res_oor = 1'b0;
    endcase
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      total_q <= res_total;
      used_q  <= res_used;
      oor_q   <= res_oor;
      sat_q   <= res_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_total_o = total_q;
  assign out_used_o  = used_q;
  assign out_oor_o   = oor_q;
  assign out_sat_o   = sat_q;

  assign sts_o.in_act     = in_action_i;
  assign sts_o.in_hit     = in_hit;
  assign sts_o.act_q      = act_q;
  assign sts_o.ext_zero   = eff_ext == '0;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

FILE: hdl/snh_ctrl.sv
module snh_ctrl
  import snh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_act)
            ACT_CLEAR: state_d = sts_i.ext_zero ? ST_DONE : ST_CLEAR;
            ACT_COUNT: state_d = sts_i.in_hit ? ST_READ : ST_DONE;
            ACT_READ:  state_d = sts_i.in_hit ? ST_READ : ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        state_d = (sts_i.act_q == ACT_COUNT) ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: state_d = ST_DONE;
      ST_CLEAR: begin
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep     = 1'b1;
        cmd_o.sweep_all = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_READ:   cmd_o.mem_rd   = 1'b1;
      ST_UPDATE: cmd_o.mem_inc  = 1'b1;
      ST_CLEAR:  cmd_o.sweep    = 1'b1;
      ST_DONE:   cmd_o.out_load = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/slice_nonzero_histogram.sv
// Slice nonzero histogram: one counter per slice of the configured tensor mode.
// Input words arrive on s_axis (tuser = action, tdata = coordinates and read
// slot); one result word per input word leaves on m_axis. The cfg channel
// writes slice_mode (index 0) and slice_extent (index 1); it is always ready.
// Steps from input accept to result valid, with the output free:
//   count in range: counter read, increment and write back, result load
//   read in range:  counter read, result load
//   out of range or no-op: result load only
//   clear: slots below the extent zeroed, one slot per cycle, then result load
// A new word is taken once the previous one has been handed to the output
// register, so the block never works on two words at once.
// After reset the block zeroes all SLICE_SLOTS counters, one per cycle, with
// s_axis_tready low; configuration writes are taken during that pass.
// When m_axis_tready is low the result stays in the output register, and the
// next word is processed up to its result load, where it waits.
module slice_nonzero_histogram
  import snh_pkg::*;
#(
  parameter int unsigned NUM_MODES   = 4,
  parameter int unsigned SLICE_SLOTS = 4096,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // coord_0, coord_1, coord_2, coord_3, read_slot, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [ActW-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // slot_total, slot_used, out_of_range, saturated, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [ExtW-1:0]     cfg_data_i
);

  logic [NumCoords-1:0][CoordW-1:0] in_coord;
  logic [SlotW-1:0]                 in_read_slot;
  ctrl_cmd_t                        cmd;
  ctrl_sts_t                        sts;
  logic [TotalW-1:0]                out_total;
  logic [SlotW-1:0]                 out_used;
  logic                             out_oor;
  logic                             out_sat;

  always_comb begin
    for (int k = 0; k < NumCoords; k++) begin
      in_coord[k] = s_axis_tdata[k*CoordW +: CoordW];
    end
  end

  assign in_read_slot = s_axis_tdata[NumCoords*CoordW +: SlotW];
  assign cfg_ready_o  = 1'b1;

  snh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  snh_dp #(
    .NUM_MODES   (NUM_MODES),
    .SLICE_SLOTS (SLICE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (reg_idx_e'(cfg_index_i)),
    .cfg_data_i     (cfg_data_i),
    .in_action_i    (action_e'(s_axis_tuser)),
    .in_coord_i     (in_coord),
    .in_read_slot_i (in_read_slot),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_total_o    (out_total),
    .out_used_o     (out_used),
    .out_oor_o      (out_oor),
    .out_sat_o      (out_sat)
  );

  assign m_axis_tdata = {{(OutDataW - OutBits){1'b0}}, out_sat, out_oor, out_used, out_total};

endmodule
